// File: rtl/cws_pkg.sv
// shared types, constants and calendar helpers for the calendar wait seconds unit
// no dependencies; used by every module of the block
package cws_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  localparam int unsigned WaitW  = 40;
  localparam int unsigned EdaysW = 23;
  // day count before wrapping, wide enough for any start year
  localparam int unsigned DaysW  = 25;
  // time-of-day difference in seconds
  localparam int unsigned TodW   = 20;

  localparam logic [YearW-1:0] YearMin = YearW'(1800);
  localparam logic [YearW-1:0] YearMax = YearW'(9999);

  localparam int unsigned DaysPerYear  = 360;
  localparam int unsigned DaysPerMonth = 30;
  localparam int unsigned SecPerDay    = 86400;
  localparam int unsigned SecPerHour   = 3600;
  localparam int unsigned SecPerMin    = 60;
  localparam int unsigned MinPerHour   = 60;
  localparam int unsigned MonPerYear   = 12;

  // y is a multiple of 25 when y * inv(25) mod 2^14 lands at or below this bound
  localparam logic [YearW-1:0] Inv25 = YearW'(7209);
  localparam logic [YearW-1:0] Max25 = YearW'(((1 << YearW) - 1) / 25);

  localparam logic [MonthW-1:0] MonJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonMar = MonthW'(3);
  localparam logic [MonthW-1:0] MonApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonMay = MonthW'(5);
  localparam logic [MonthW-1:0] MonJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonJul = MonthW'(7);
  localparam logic [MonthW-1:0] MonSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonOct = MonthW'(10);
  localparam logic [MonthW-1:0] MonNov = MonthW'(11);
  localparam logic [MonthW-1:0] MonDec = MonthW'(12);

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } tod_t;

  // date checker status toward the span logic
  typedef struct packed {
    logic ok;
    logic leap;
  } date_stat_t;

  // days that a day borrow adds, taken from the month before the end month
  function automatic logic [DayW-1:0] borrow_days(input logic [MonthW-1:0] m,
                                                  input logic leap);
    logic [DayW-1:0] len;
    len = DayW'(31);
    if (m == MonMar) begin
      len = leap ? DayW'(29) : DayW'(28);
    end else if (m inside {MonMay, MonJul, MonOct, MonDec}) begin
      len = DayW'(30);
    end
    return len;
  endfunction

endpackage

// File: rtl/cws_date_check.sv
// validity check and gregorian leap year test for one date
// depends on cws_pkg
module cws_date_check (
  input  cws_pkg::date_t     date_i,
  output cws_pkg::date_stat_t stat_o
);

  logic [cws_pkg::YearW-1:0] y_inv;
  logic                      div25;
  logic                      leap;
  logic                      year_ok;
  logic                      day_ok;

  assign y_inv = cws_pkg::YearW'(date_i.year * cws_pkg::Inv25);
  assign div25 = (y_inv <= cws_pkg::Max25);
  // century years only count when divisible by 400
  assign leap  = ((date_i.year[1:0] == 2'b00) && !div25) ||
                 ((date_i.year[3:0] == 4'b0000) && div25);

  assign year_ok = (date_i.year >= cws_pkg::YearMin) && (date_i.year <= cws_pkg::YearMax);

  // no lower bound on the day, so day zero passes
  always_comb begin
    day_ok = 1'b0;
    if (date_i.month == cws_pkg::MonFeb) begin
      day_ok = (leap && (date_i.day == cws_pkg::DayW'(29))) ||
               (date_i.day <= cws_pkg::DayW'(28));
    end else if (date_i.month inside {cws_pkg::MonApr, cws_pkg::MonJun,
                                      cws_pkg::MonSep, cws_pkg::MonNov}) begin
      day_ok = (date_i.day <= cws_pkg::DayW'(30));
    end else if ((date_i.month >= cws_pkg::MonJan) && (date_i.month <= cws_pkg::MonDec)) begin
      day_ok = 1'b1;
    end
  end

  assign stat_o.ok   = year_ok && day_ok;
  assign stat_o.leap = leap;

endmodule

// File: rtl/cws_span.sv
// borrow subtraction of two dates (360-day year) and two times of day
// depends on cws_pkg
module cws_span (
  input  cws_pkg::date_t                    start_date_i,
  input  cws_pkg::date_t                    end_date_i,
  input  logic                              end_leap_i,
  input  cws_pkg::tod_t                     start_tod_i,
  input  cws_pkg::tod_t                     stop_tod_i,
  output logic signed [cws_pkg::DaysW-1:0]  days_o,
  output logic signed [cws_pkg::TodW-1:0]   tod_secs_o
);

  localparam int unsigned DW = cws_pkg::DaysW;
  localparam int unsigned TW = cws_pkg::TodW;

  logic                 day_borrow;
  logic [6:0]           d2_adj;
  logic signed [5:0]    m1;
  logic signed [5:0]    m2_adj;
  logic signed [5:0]    m2_fix;
  logic                 mon_borrow;
  logic signed [DW-1:0] y_diff;
  logic signed [DW-1:0] m_diff;
  logic signed [DW-1:0] d_diff;

  logic                 sec_borrow;
  logic                 min_borrow;
  logic signed [7:0]    es_adj;
  logic signed [7:0]    em_adj;
  logic signed [7:0]    em_fix;
  logic signed [6:0]    eh_adj;
  logic signed [TW-1:0] h_diff;
  logic signed [TW-1:0] mi_diff;
  logic signed [TW-1:0] s_diff;

  // date part
  assign day_borrow = (end_date_i.day < start_date_i.day);
  assign d2_adj     = 7'(end_date_i.day) +
                      (day_borrow ? 7'(cws_pkg::borrow_days(end_date_i.month, end_leap_i))
                                  : 7'd0);
  assign m1         = $signed({2'b00, start_date_i.month});
  assign m2_adj     = $signed({2'b00, end_date_i.month}) - (day_borrow ? 6'sd1 : 6'sd0);
  assign mon_borrow = (m2_adj < m1);
  assign m2_fix     = m2_adj + (mon_borrow ? 6'(cws_pkg::MonPerYear) : 6'sd0);

  assign y_diff = $signed(DW'(end_date_i.year)) - $signed(DW'(start_date_i.year)) -
                  (mon_borrow ? DW'(1) : DW'(0));
  assign m_diff = DW'(m2_fix - m1);
  assign d_diff = $signed(DW'(d2_adj)) - $signed(DW'(start_date_i.day));

  assign days_o = DW'(y_diff * $signed(DW'(cws_pkg::DaysPerYear))) +
                  DW'(m_diff * $signed(DW'(cws_pkg::DaysPerMonth))) + d_diff;

  // time part
  assign sec_borrow = (start_tod_i.second > stop_tod_i.second);
  assign es_adj     = $signed(8'(stop_tod_i.second)) +
                      (sec_borrow ? 8'(cws_pkg::SecPerMin) : 8'sd0);
  assign em_adj     = $signed(8'(stop_tod_i.minute)) - (sec_borrow ? 8'sd1 : 8'sd0);
  assign min_borrow = ($signed(8'(start_tod_i.minute)) > em_adj);
  assign em_fix     = em_adj + (min_borrow ? 8'(cws_pkg::MinPerHour) : 8'sd0);
  assign eh_adj     = $signed(7'(stop_tod_i.hour)) - (min_borrow ? 7'sd1 : 7'sd0);

  assign h_diff  = TW'(eh_adj) - $signed(TW'(start_tod_i.hour));
  assign mi_diff = TW'(em_fix) - $signed(TW'(start_tod_i.minute));
  assign s_diff  = TW'(es_adj) - $signed(TW'(start_tod_i.second));

  assign tod_secs_o = TW'(h_diff * $signed(TW'(cws_pkg::SecPerHour))) +
                      TW'(mi_diff * $signed(TW'(cws_pkg::SecPerMin))) + s_diff;

endmodule

// File: rtl/calendar_wait_seconds_unit.sv
// top level of the calendar wait seconds unit: input register, span stage, result register
// depends on cws_pkg, cws_date_check and cws_span
//
// A new item is taken in every cycle (busy stays low) and its result is built in order: the
// fields are registered, the date checks and the borrow subtraction fill a second register,
// and the scaling of the day count by 86400 (one constant multiply) fills the result
// register. done_o is high for exactly one cycle per item and results are not held, so
// the receiver must take each one as it appears. When the end date fails its check,
// wait_seconds_o and elapsed_days_o read 0; an invalid start date is only flagged.
// elapsed_days_o wraps to 23 bits, wait_seconds_o always fits.
module calendar_wait_seconds_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cws_pkg::DayW-1:0]           start_day_i,
  input  logic [cws_pkg::MonthW-1:0]         start_month_i,
  input  logic [cws_pkg::YearW-1:0]          start_year_i,
  input  logic [cws_pkg::DayW-1:0]           end_day_i,
  input  logic [cws_pkg::MonthW-1:0]         end_month_i,
  input  logic [cws_pkg::YearW-1:0]          end_year_i,
  input  logic [cws_pkg::HourW-1:0]          start_hour_i,
  input  logic [cws_pkg::MinW-1:0]           start_minute_i,
  input  logic [cws_pkg::SecW-1:0]           start_second_i,
  input  logic [cws_pkg::HourW-1:0]          stop_hour_i,
  input  logic [cws_pkg::MinW-1:0]           stop_minute_i,
  input  logic [cws_pkg::SecW-1:0]           stop_second_i,
  output logic                               done_o,
  output logic signed [cws_pkg::WaitW-1:0]   wait_seconds_o,
  output logic signed [cws_pkg::EdaysW-1:0]  elapsed_days_o,
  output logic                               start_date_ok_o,
  output logic                               end_date_ok_o
);

  localparam int unsigned DW = cws_pkg::DaysW;
  localparam int unsigned TW = cws_pkg::TodW;
  localparam int unsigned WW = cws_pkg::WaitW;

  // input register
  logic           in_vld_q;
  cws_pkg::date_t sd_q, ed_q;
  cws_pkg::tod_t  st_q, et_q;

  // span stage
  cws_pkg::date_stat_t  sd_stat, ed_stat;
  logic signed [DW-1:0] days;
  logic signed [TW-1:0] tod_secs;

  logic                 mid_vld_q;
  logic                 ok1_q, ok2_q;
  logic signed [DW-1:0] days_q;
  logic signed [TW-1:0] tod_q;

  // result register
  logic                 done_q;
  logic signed [WW-1:0] wait_d, wait_q;
  logic signed [cws_pkg::EdaysW-1:0] edays_q;
  logic                 ok1_out_q, ok2_out_q;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      mid_vld_q <= in_vld_q;
      done_q    <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sd_q <= '{day: start_day_i, month: start_month_i, year: start_year_i};
      ed_q <= '{day: end_day_i, month: end_month_i, year: end_year_i};
      st_q <= '{hour: start_hour_i, minute: start_minute_i, second: start_second_i};
      et_q <= '{hour: stop_hour_i, minute: stop_minute_i, second: stop_second_i};
    end
  end

  cws_date_check u_start_check (
    .date_i (sd_q),
    .stat_o (sd_stat)
  );

  cws_date_check u_end_check (
    .date_i (ed_q),
    .stat_o (ed_stat)
  );

  cws_span u_span (
    .start_date_i (sd_q),
    .end_date_i   (ed_q),
    .end_leap_i   (ed_stat.leap),
    .start_tod_i  (st_q),
    .stop_tod_i   (et_q),
    .days_o       (days),
    .tod_secs_o   (tod_secs)
  );

  // bad end date forces both counts to zero
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      ok1_q  <= sd_stat.ok;
      ok2_q  <= ed_stat.ok;
      days_q <= ed_stat.ok ? days : '0;
      tod_q  <= ed_stat.ok ? tod_secs : '0;
    end
  end

  assign wait_d = WW'($signed(WW'(days_q)) * $signed(WW'(cws_pkg::SecPerDay))) +
                  $signed(WW'(tod_q));

  always_ff @(posedge clk_i) begin
    if (mid_vld_q) begin
      wait_q    <= wait_d;
      edays_q   <= days_q[cws_pkg::EdaysW-1:0];
      ok1_out_q <= ok1_q;
      ok2_out_q <= ok2_q;
    end
  end

  assign done_o          = done_q;
  assign wait_seconds_o  = wait_q;
  assign elapsed_days_o  = edays_q;
  assign start_date_ok_o = ok1_out_q;
  assign end_date_ok_o   = ok2_out_q;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted beat did not produce a result after three cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3))
    else $error("result strobe without an accepted beat");

  a_bad_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !end_date_ok_o) |-> (wait_seconds_o == '0) && (elapsed_days_o == '0))
    else $error("nonzero result for an invalid end date");

endmodule

// File: tb/sv/calendar_wait_seconds_unit_tb.sv
// self-checking testbench for calendar_wait_seconds_unit: date checks, borrow subtraction, wait
// depends on cws_pkg for widths, month codes and the date/time structs; no files, no arguments
module calendar_wait_seconds_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     StallLimit = 500;
  localparam longint YearDays   = 360;
  localparam longint MonthDays  = 30;
  localparam longint DaySecs    = 86400;
  localparam longint HourSecs   = 3600;
  localparam longint MinSecs    = 60;

  typedef struct packed {
    cws_pkg::date_t from_date;
    cws_pkg::date_t to_date;
    cws_pkg::tod_t  from_tod;
    cws_pkg::tod_t  to_tod;
  } span_req_t;

  typedef struct packed {
    logic [cws_pkg::WaitW-1:0]  secs;
    logic [cws_pkg::EdaysW-1:0] days;
    logic                       from_ok;
    logic                       to_ok;
  } wait_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic [cws_pkg::DayW-1:0]   start_day_i    = '0;
  logic [cws_pkg::MonthW-1:0] start_month_i  = '0;
  logic [cws_pkg::YearW-1:0]  start_year_i   = '0;
  logic [cws_pkg::DayW-1:0]   end_day_i      = '0;
  logic [cws_pkg::MonthW-1:0] end_month_i    = '0;
  logic [cws_pkg::YearW-1:0]  end_year_i     = '0;
  logic [cws_pkg::HourW-1:0]  start_hour_i   = '0;
  logic [cws_pkg::MinW-1:0]   start_minute_i = '0;
  logic [cws_pkg::SecW-1:0]   start_second_i = '0;
  logic [cws_pkg::HourW-1:0]  stop_hour_i    = '0;
  logic [cws_pkg::MinW-1:0]   stop_minute_i  = '0;
  logic [cws_pkg::SecW-1:0]   stop_second_i  = '0;
  logic                              done_o;
  logic signed [cws_pkg::WaitW-1:0]  wait_seconds_o;
  logic signed [cws_pkg::EdaysW-1:0] elapsed_days_o;
  logic                              start_date_ok_o;
  logic                              end_date_ok_o;

  wait_result_t pending_waits[$];
  int err_count   = 0;
  int beats_seen  = 0;
  int spans_sent  = 0;
  int bad_end     = 0;
  int bad_start   = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  calendar_wait_seconds_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .end_day_i      (end_day_i),
    .end_month_i    (end_month_i),
    .end_year_i     (end_year_i),
    .start_hour_i   (start_hour_i),
    .start_minute_i (start_minute_i),
    .start_second_i (start_second_i),
    .stop_hour_i    (stop_hour_i),
    .stop_minute_i  (stop_minute_i),
    .stop_second_i  (stop_second_i),
    .done_o         (done_o),
    .wait_seconds_o (wait_seconds_o),
    .elapsed_days_o (elapsed_days_o),
    .start_date_ok_o(start_date_ok_o),
    .end_date_ok_o  (end_date_ok_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- calendar prediction

  function automatic bit is_leap(input logic [cws_pkg::YearW-1:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // length of a valid month; anything that is not a 30-day month or February has 31
  function automatic int unsigned month_days(input logic [cws_pkg::MonthW-1:0] m,
                                             input logic [cws_pkg::YearW-1:0] y);
    if (m == cws_pkg::MonFeb) begin
      return is_leap(y) ? 29 : 28;
    end
    if (m == cws_pkg::MonApr || m == cws_pkg::MonJun ||
        m == cws_pkg::MonSep || m == cws_pkg::MonNov) begin
      return 30;
    end
    return 31;
  endfunction

  // no lower bound on the day, so day zero passes
  function automatic bit date_valid(input cws_pkg::date_t dt);
    if (dt.year < cws_pkg::YearMin || dt.year > cws_pkg::YearMax) begin
      return 1'b0;
    end
    if (dt.month < cws_pkg::MonJan || dt.month > cws_pkg::MonDec) begin
      return 1'b0;
    end
    return 32'(dt.day) <= month_days(dt.month, dt.year);
  endfunction

  function automatic wait_result_t calc_wait(input span_req_t r);
    longint d1, m1, y1, d2, m2, y2;
    longint sh, sm, ss, eh, em, es;
    longint ndays, nsecs;
    logic [cws_pkg::MonthW-1:0] prev_month;
    wait_result_t res;
    d1 = longint'(r.from_date.day);
    m1 = longint'(r.from_date.month);
    y1 = longint'(r.from_date.year);
    d2 = longint'(r.to_date.day);
    m2 = longint'(r.to_date.month);
    y2 = longint'(r.to_date.year);
    sh = longint'(r.from_tod.hour);
    sm = longint'(r.from_tod.minute);
    ss = longint'(r.from_tod.second);
    eh = longint'(r.to_tod.hour);
    em = longint'(r.to_tod.minute);
    es = longint'(r.to_tod.second);
    ndays = 0;
    nsecs = 0;
    if (date_valid(r.to_date)) begin
      if (d2 < d1) begin
        // borrow the length of the month before the end month
        prev_month = (r.to_date.month == cws_pkg::MonJan) ? cws_pkg::MonDec
                                                           : r.to_date.month - 4'd1;
        d2 += longint'(month_days(prev_month, r.to_date.year));
        m2 -= 1;
      end
      if (m2 < m1) begin
        m2 += 12;
        y2 -= 1;
      end
      ndays = (y2 - y1) * YearDays + (m2 - m1) * MonthDays + (d2 - d1);
      if (ss > es) begin
        es += 60;
        em -= 1;
      end
      if (sm > em) begin
        em += 60;
        eh -= 1;
      end
      nsecs = ndays * DaySecs + (eh - sh) * HourSecs + (em - sm) * MinSecs + (es - ss);
    end
    res.secs    = nsecs[cws_pkg::WaitW-1:0];
    res.days    = ndays[cws_pkg::EdaysW-1:0];
    res.from_ok = date_valid(r.from_date);
    res.to_ok   = date_valid(r.to_date);
    return res;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(199, 0);
    if (roll == 0) begin
      burst_left = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 120) return 0;
    if (roll < 185) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // start stays high across back-to-back beats; it only drops when a gap follows
  task automatic send_span(input span_req_t req);
    int gap;
    start          <= 1'b1;
    start_day_i    <= req.from_date.day;
    start_month_i  <= req.from_date.month;
    start_year_i   <= req.from_date.year;
    end_day_i      <= req.to_date.day;
    end_month_i    <= req.to_date.month;
    end_year_i     <= req.to_date.year;
    start_hour_i   <= req.from_tod.hour;
    start_minute_i <= req.from_tod.minute;
    start_second_i <= req.from_tod.second;
    stop_hour_i    <= req.to_tod.hour;
    stop_minute_i  <= req.to_tod.minute;
    stop_second_i  <= req.to_tod.second;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_waits.push_back(calc_wait(req));
    spans_sent++;
    if (!date_valid(req.to_date)) bad_end++;
    if (!date_valid(req.from_date)) bad_start++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic span_req_t span_of(input int d1, m1, y1, d2, m2, y2,
                                        input int sh, sm, ss, eh, em, es);
    span_req_t r;
    r.from_date = '{day: cws_pkg::DayW'(d1), month: cws_pkg::MonthW'(m1),
                    year: cws_pkg::YearW'(y1)};
    r.to_date   = '{day: cws_pkg::DayW'(d2), month: cws_pkg::MonthW'(m2),
                    year: cws_pkg::YearW'(y2)};
    r.from_tod  = '{hour: cws_pkg::HourW'(sh), minute: cws_pkg::MinW'(sm),
                    second: cws_pkg::SecW'(ss)};
    r.to_tod    = '{hour: cws_pkg::HourW'(eh), minute: cws_pkg::MinW'(em),
                    second: cws_pkg::SecW'(es)};
    return r;
  endfunction

  function automatic cws_pkg::date_t rand_date();
    cws_pkg::date_t dt;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 85) begin
      dt.year = cws_pkg::YearW'($urandom_range(9999, 1800));
    end else if (roll < 95) begin
      case ($urandom_range(3, 0))
        0:       dt.year = 1799;
        1:       dt.year = 1800;
        2:       dt.year = 9999;
        default: dt.year = 10000;
      endcase
    end else begin
      dt.year = cws_pkg::YearW'($urandom_range(16383, 0));
    end
    if ($urandom_range(19, 0) == 0) begin
      dt.month = cws_pkg::MonFeb;
      dt.day   = 29;
    end else begin
      dt.month = ($urandom_range(9, 0) == 0) ? cws_pkg::MonthW'($urandom_range(15, 0))
                                             : cws_pkg::MonthW'($urandom_range(12, 1));
      if (dt.month >= cws_pkg::MonJan && dt.month <= cws_pkg::MonDec) begin
        dt.day = cws_pkg::DayW'($urandom_range(month_days(dt.month, dt.year), 0));
        if ($urandom_range(19, 0) == 0) begin
          dt.day = cws_pkg::DayW'(month_days(dt.month, dt.year) + 1);
        end
      end else begin
        dt.day = cws_pkg::DayW'($urandom_range(31, 0));
      end
    end
    return dt;
  endfunction

  function automatic cws_pkg::tod_t rand_tod();
    cws_pkg::tod_t t;
    logic [31:0]   raw;
    if ($urandom_range(9, 0) == 0) begin
      raw = $urandom();
      t   = raw[$bits(cws_pkg::tod_t)-1:0];
    end else begin
      t.hour   = cws_pkg::HourW'($urandom_range(23, 0));
      t.minute = cws_pkg::MinW'($urandom_range(59, 0));
      t.second = cws_pkg::SecW'($urandom_range(59, 0));
    end
    return t;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    // all zero, then every field at its maximum
    send_span(span_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_span(span_of(31, 15, 16383, 31, 15, 16383, 31, 63, 63, 31, 63, 63));
    // widest valid span forward and backward
    send_span(span_of(1, 1, 1800, 31, 12, 9999, 0, 0, 0, 23, 59, 59));
    send_span(span_of(31, 12, 9999, 1, 1, 1800, 23, 59, 59, 0, 0, 0));
    // day zero is accepted
    send_span(span_of(0, 1, 2000, 0, 3, 2000, 12, 0, 0, 12, 0, 0));
    // february 29 in leap and common years
    send_span(span_of(29, 2, 2000, 29, 2, 2024, 1, 2, 3, 4, 5, 6));
    send_span(span_of(1, 1, 1900, 29, 2, 1900, 0, 0, 0, 0, 0, 0));
    send_span(span_of(29, 2, 2023, 1, 3, 2023, 0, 0, 0, 0, 0, 0));
    send_span(span_of(29, 2, 2100, 29, 2, 2400, 0, 0, 0, 0, 0, 0));
    // year bounds on the end date
    send_span(span_of(1, 1, 1800, 1, 1, 1799, 0, 0, 0, 0, 0, 0));
    send_span(span_of(1, 1, 1800, 1, 1, 10000, 0, 0, 0, 0, 0, 0));
    // bad start year: large forward count, then one that wraps the day count
    send_span(span_of(0, 0, 0, 31, 12, 9999, 0, 0, 0, 23, 59, 59));
    send_span(span_of(31, 1, 16383, 1, 1, 1800, 0, 0, 0, 0, 0, 0));
    // month bounds
    send_span(span_of(1, 1, 2000, 1, 0, 2000, 0, 0, 0, 0, 0, 0));
    send_span(span_of(1, 1, 2000, 1, 13, 2000, 0, 0, 0, 0, 0, 0));
    send_span(span_of(1, 15, 2000, 1, 12, 2000, 0, 0, 0, 0, 0, 0));
    // 30-day month limit
    send_span(span_of(1, 1, 2000, 31, 4, 2000, 0, 0, 0, 0, 0, 0));
    send_span(span_of(1, 1, 2000, 30, 4, 2000, 0, 0, 0, 0, 0, 0));
    // day borrows into february (leap and not), a 30-day month, and across new year
    send_span(span_of(30, 1, 2024, 1, 3, 2024, 0, 0, 0, 0, 0, 0));
    send_span(span_of(30, 1, 2023, 1, 3, 2023, 0, 0, 0, 0, 0, 0));
    send_span(span_of(31, 1, 2020, 5, 5, 2020, 0, 0, 0, 0, 0, 0));
    send_span(span_of(20, 6, 2019, 10, 1, 2020, 0, 0, 0, 0, 0, 0));
    // time borrows, a negative time part, and time fields past their range
    send_span(span_of(5, 5, 2005, 5, 5, 2005, 0, 59, 59, 1, 0, 0));
    send_span(span_of(5, 5, 2005, 5, 5, 2005, 23, 59, 59, 0, 0, 0));
    send_span(span_of(5, 5, 2005, 6, 5, 2005, 31, 63, 63, 0, 0, 0));
  endtask

  task automatic test_valid_spans(input int count);
    span_req_t req;
    for (int i = 0; i < count; i++) begin
      req.from_date = rand_date();
      req.to_date   = rand_date();
      // keep many spans short so the borrows meet nearby dates
      if ($urandom_range(9, 0) < 3) begin
        req.to_date.year = req.from_date.year + cws_pkg::YearW'($urandom_range(2, 0));
      end
      req.from_tod = rand_tod();
      req.to_tod   = rand_tod();
      send_span(req);
    end
  endtask

  task automatic test_raw_fields(input int count);
    bit [95:0] noise;
    for (int i = 0; i < count; i++) begin
      noise = {$urandom(), $urandom(), $urandom()};
      send_span(span_req_t'(noise[$bits(span_req_t)-1:0]));
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string what, input longint want, input longint seen);
    if (want != seen) begin
      err_count++;
      if (err_count <= 10) begin
        $display("mismatch on %s in beat %0d: expected %0d, got %0d",
                 what, beats_seen, want, seen);
      end
    end
  endtask

  always @(posedge clk_i) begin
    wait_result_t want;
    if (rst_ni && done_o) begin
      if (pending_waits.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("result beat %0d with nothing outstanding", beats_seen);
      end else begin
        want = pending_waits.pop_front();
        check_field("wait_seconds", longint'($signed(want.secs)), longint'(wait_seconds_o));
        check_field("elapsed_days", longint'($signed(want.days)), longint'(elapsed_days_o));
        check_field("start_date_ok", longint'(want.from_ok), longint'(start_date_ok_o));
        check_field("end_date_ok", longint'(want.to_ok), longint'(end_date_ok_o));
      end
      beats_seen++;
    end
  end

  // stall watchdog: any beat on either side restarts the count
  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("no progress for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_waits.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_valid_spans(800);
    test_raw_fields(250);
    start <= 1'b0;
    while (pending_waits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d date/time pairs checked over %0d result beats", spans_sent, beats_seen);
    $display("end date rejected in %0d, start date rejected in %0d", bad_end, bad_start);
    if (err_count == 0 && pending_waits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d results missing", err_count, pending_waits.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cws_pkg.sv
rtl/cws_date_check.sv
rtl/cws_span.sv
rtl/calendar_wait_seconds_unit.sv
tb/sv/calendar_wait_seconds_unit_tb.sv
